### rtl/c_escape_decoder_assert.svh
// Assertion macros for the escape decoder.
`ifndef C_ESCAPE_DECODER_ASSERT_SVH
`define C_ESCAPE_DECODER_ASSERT_SVH

`ifndef SYNTH
`define CED_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("escape decoder check failed");
`define CED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("escape decoder check failed");
`else
`define CED_ASSERT(lbl, clk, rstn, prop)
`define CED_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/ced_pkg.sv
`timescale 1ns / 1ps

package ced_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int MAX_RES  = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);
    localparam int CNT_W    = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]            count;
        result_t [MAX_RES-1:0]       res;
    } push_t;

    // {valid, byte}
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h27:    r = {1'b1, 8'h27};
            CH_BSLASH: r = {1'b1, 8'h5C};
            8'h22:    r = {1'b1, 8'h22};
            CH_QMARK: r = {1'b1, 8'h3F};
            8'h61:    r = {1'b1, 8'h07};
            8'h62:    r = {1'b1, 8'h08};
            8'h66:    r = {1'b1, 8'h0C};
            8'h6E:    r = {1'b1, 8'h0A};
            8'h72:    r = {1'b1, 8'h0D};
            8'h74:    r = {1'b1, 8'h09};
            8'h76:    r = {1'b1, 8'h0B};
            default:  r = 9'd0;
        endcase
        return r;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

### rtl/ced_core.sv
`timescale 1ns / 1ps

module ced_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           last,
    output ced_pkg::push_t push
);
    import ced_pkg::*;

    localparam logic [2:0] PH_NORMAL = 3'd0;
    localparam logic [2:0] PH_ESC    = 3'd1;
    localparam logic [2:0] PH_HEX    = 3'd2;
    localparam logic [2:0] PH_OCT    = 3'd3;
    localparam logic [2:0] PH_DROP   = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [30:0] val_reg, val_next;
    logic        ovf_reg, ovf_next;
    logic        hx_reg, hx_next;

    logic [8:0]  simp;
    logic [4:0]  hexv;
    logic        is_oct;
    logic [30:0] acc_val;
    logic        acc_ovf;
    logic        do_normal;
    logic [CNT_W-1:0] n;
    logic [7:0]  run_byte;

    assign simp   = simple_escape(in_byte);
    assign hexv   = hex_value(in_byte);
    assign is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);

    always_comb begin
        phase_next = phase_reg;
        val_next   = val_reg;
        ovf_next   = ovf_reg;
        hx_next    = hx_reg;
        do_normal  = 1'b0;
        n          = '0;
        push.res   = '0;
        acc_val    = val_reg;
        acc_ovf    = ovf_reg;
        run_byte   = 8'd0;

        case (phase_reg)
            PH_DROP: begin
                if (last) begin
                    phase_next = PH_NORMAL;
                    val_next   = '0;
                    ovf_next   = 1'b0;
                    hx_next    = 1'b0;
                end
            end
            PH_ESC: begin
                if (simp[8]) begin
                    phase_next = PH_NORMAL;
                    push.res[n] = '{data: simp[7:0], kind: KIND_DATA};
                    n = n + 1'b1;
                    if (last) begin
                        push.res[n] = '{data: 8'd0, kind: KIND_END};
                        n = n + 1'b1;
                    end
                end else if (in_byte == CH_X) begin
                    val_next = '0;
                    ovf_next = 1'b0;
                    hx_next  = 1'b0;
                    if (last) begin
                        push.res[n] = '{data: 8'd0, kind: KIND_ERR};
                        n = n + 1'b1;
                        phase_next = PH_NORMAL;
                    end else begin
                        phase_next = PH_HEX;
                    end
                end else if (is_oct) begin
                    ovf_next = 1'b0;
                    hx_next  = 1'b0;
                    if (last) begin
                        push.res[n] = '{data: {5'd0, in_byte[2:0]}, kind: KIND_DATA};
                        n = n + 1'b1;
                        push.res[n] = '{data: 8'd0, kind: KIND_END};
                        n = n + 1'b1;
                        val_next   = '0;
                        phase_next = PH_NORMAL;
                    end else begin
                        val_next   = {28'd0, in_byte[2:0]};
                        phase_next = PH_OCT;
                    end
                end else begin
                    // \u, \U and unknown escapes all fail
                    push.res[n] = '{data: 8'd0, kind: KIND_ERR};
                    n = n + 1'b1;
                    val_next   = '0;
                    ovf_next   = 1'b0;
                    hx_next    = 1'b0;
                    phase_next = last ? PH_NORMAL : PH_DROP;
                end
            end
            PH_HEX, PH_OCT: begin
                if ((phase_reg == PH_HEX) ? hexv[4] : is_oct) begin
                    // overflow past 0x7FFFFFFF shows in the top bits before the shift
                    if (!ovf_reg) begin
                        if (phase_reg == PH_HEX) begin
                            if (val_reg[30:27] != 4'd0) begin
                                acc_ovf = 1'b1;
                            end else begin
                                acc_val = {val_reg[26:0], hexv[3:0]};
                            end
                        end else begin
                            if (val_reg[30:28] != 3'd0) begin
                                acc_ovf = 1'b1;
                            end else begin
                                acc_val = {val_reg[27:0], in_byte[2:0]};
                            end
                        end
                    end
                    if (last) begin
                        run_byte = acc_ovf ? 8'hFF : acc_val[7:0];
                        push.res[n] = '{data: run_byte, kind: KIND_DATA};
                        n = n + 1'b1;
                        push.res[n] = '{data: 8'd0, kind: KIND_END};
                        n = n + 1'b1;
                        val_next   = '0;
                        ovf_next   = 1'b0;
                        hx_next    = 1'b0;
                        phase_next = PH_NORMAL;
                    end else begin
                        val_next = acc_val;
                        ovf_next = acc_ovf;
                        hx_next  = (phase_reg == PH_HEX) | hx_reg;
                    end
                end else if ((phase_reg == PH_HEX) && !hx_reg) begin
                    // \x with no digit
                    push.res[n] = '{data: 8'd0, kind: KIND_ERR};
                    n = n + 1'b1;
                    val_next   = '0;
                    ovf_next   = 1'b0;
                    hx_next    = 1'b0;
                    phase_next = last ? PH_NORMAL : PH_DROP;
                end else begin
                    run_byte = ovf_reg ? 8'hFF : val_reg[7:0];
                    push.res[n] = '{data: run_byte, kind: KIND_DATA};
                    n = n + 1'b1;
                    val_next  = '0;
                    ovf_next  = 1'b0;
                    hx_next   = 1'b0;
                    do_normal = 1'b1;
                end
            end
            default: begin
                do_normal = 1'b1;
            end
        endcase

        // plain text handling, also for the byte that ends a digit run
        if (do_normal) begin
            phase_next = PH_NORMAL;
            if (in_byte == CH_BSLASH) begin
                if (last) begin
                    push.res[n] = '{data: 8'd0, kind: KIND_ERR};
                    n = n + 1'b1;
                end else begin
                    phase_next = PH_ESC;
                end
            end else begin
                push.res[n] = '{data: in_byte, kind: KIND_DATA};
                n = n + 1'b1;
                if (last) begin
                    push.res[n] = '{data: 8'd0, kind: KIND_END};
                    n = n + 1'b1;
                end
            end
        end

        push.count = accept ? n : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            val_reg   <= '0;
            ovf_reg   <= 1'b0;
            hx_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            val_reg   <= val_next;
            ovf_reg   <= ovf_next;
            hx_reg    <= hx_next;
        end
    end

endmodule

### rtl/ced_queue.sv
`timescale 1ns / 1ps
`include "c_escape_decoder_assert.svh"

module ced_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  ced_pkg::push_t   push,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output ced_pkg::result_t head
);
    import ced_pkg::*;

    result_t         mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next;
    logic [Q_AW-1:0] rd_reg, rd_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != '0);
    assign head    = mem_reg[rd_reg];
    // room for a worst-case request of MAX_RES results
    assign room    = (cnt_reg <= Q_CW'(Q_DEPTH - MAX_RES));

    always_comb begin
        wr_next  = wr_reg + Q_AW'(push.count);
        rd_next  = rd_reg + Q_AW'(pop);
        cnt_next = cnt_reg + Q_CW'(push.count) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (CNT_W'(i) < push.count) begin
                mem_reg[wr_reg + Q_AW'(i)] <= push.res[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `CED_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= Q_CW'(Q_DEPTH))
    `CED_ASSERT(a_push_room, aclk, aresetn, (push.count == '0) || room)
    `CED_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && (push.count == '0), cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

### rtl/c_escape_decoder.sv
`timescale 1ns / 1ps
// A result is written into the result queue when the byte that causes it is taken; the queue entries drive m_.
// Throughput: one byte per cycle while results drain; a byte that yields up to three
// results holds off later bytes until the single-read result queue is back to at most one result.
// s_ready is high while the queue holds at most one result.
// Reset: synchronous, active low; returns to plain text with an empty queue.
module c_escape_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind
);
    import ced_pkg::*;

    push_t   push;
    result_t head;
    logic    accept;

    // a request is taken only when the queue can hold its worst case
    assign accept = s_valid && s_ready;

    // escape state machine and digit accumulator; up to three results per byte
    ced_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .last    (s_last),
        .push    (push)
    );

    // result queue, multi-write, single read; its entries are the output registers
    ced_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_byte = head.data;
    assign m_kind     = head.kind;

endmodule

### bench/c_escape_decoder_tb.sv
`timescale 1ns / 1ps

module c_escape_decoder_tb;

    import ced_pkg::*;

    // one byte request on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_t;

    // scan position within the string, tracked by the predictor
    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_OCT,
        SCAN_DROP
    } scan_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_last     = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_kind;

    c_escape_decoder u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // requests waiting to be driven, and decoded results still owed by the block
    req_t    byte_q[$];
    result_t decoded_q[$];

    int unsigned total_reqs;
    int unsigned taken_cnt  = 0;
    int unsigned fault_cnt  = 0;
    logic        req_taken  = 1'b0;

    // predictor state
    scan_t       scan_st    = SCAN_TEXT;
    logic [30:0] run_val    = '0;
    logic        run_ovf    = 1'b0;
    logic        run_hex    = 1'b0;

    // character sets for the string generator
    string esc_set = "'\\\"?abfnrtv";
    string hex_set = "0123456789abcdefABCDEF";

    // -------------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------------

    task automatic emit_res(input logic [7:0] d, input logic [1:0] k);
        result_t r;
        r.data = d;
        r.kind = k;
        decoded_q.insert(decoded_q.size(), r);
    endtask

    task automatic clear_run();
        run_val = '0;
        run_ovf = 1'b0;
        run_hex = 1'b0;
    endtask

    // error result; the rest of the string is swallowed unless this byte ends it
    task automatic raise_err(input logic lst);
        emit_res(8'h00, KIND_ERR);
        clear_run();
        scan_st = lst ? SCAN_TEXT : SCAN_DROP;
    endtask

    // close a digit run: low byte of the value, or 0xFF once it has saturated
    task automatic close_run();
        emit_res(run_ovf ? 8'hFF : run_val[7:0], KIND_DATA);
        clear_run();
        scan_st = SCAN_TEXT;
    endtask

    task automatic accum(input int unsigned base, input logic [3:0] d);
        logic [63:0] v;
        v = {33'd0, run_val} * base + d;
        if (run_ovf) return;
        if (v > 64'h7FFF_FFFF) begin
            run_ovf = 1'b1;
        end else begin
            run_val = v[30:0];
        end
    endtask

    // a byte met in plain text (also the byte that terminates a digit run)
    task automatic plain_byte(input logic [7:0] c, input logic lst);
        scan_st = SCAN_TEXT;
        if (c == CH_BSLASH) begin
            if (lst) begin
                raise_err(1'b1);
            end else begin
                scan_st = SCAN_ESC;
            end
        end else begin
            emit_res(c, KIND_DATA);
            if (lst) emit_res(8'h00, KIND_END);
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic lst);
        logic [7:0] simple;
        logic       is_simple;
        logic [7:0] digit;
        logic       is_hex;
        is_simple = 1'b1;
        case (c)
            "'":       simple = 8'h27;
            CH_BSLASH: simple = 8'h5C;
            "\"":      simple = 8'h22;
            CH_QMARK:  simple = 8'h3F;
            "a":       simple = 8'h07;
            "b":       simple = 8'h08;
            "f":       simple = 8'h0C;
            "n":       simple = 8'h0A;
            "r":       simple = 8'h0D;
            "t":       simple = 8'h09;
            "v":       simple = 8'h0B;
            default: begin
                simple    = 8'h00;
                is_simple = 1'b0;
            end
        endcase
        is_hex = 1'b1;
        if (c >= CH_ZERO && c <= "9") begin
            digit = c - CH_ZERO;
        end else if (c >= "a" && c <= "f") begin
            digit = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            digit = c - "A" + 8'd10;
        end else begin
            digit  = 8'h00;
            is_hex = 1'b0;
        end

        case (scan_st)
            SCAN_DROP: begin
                if (lst) begin
                    scan_st = SCAN_TEXT;
                    clear_run();
                end
            end
            SCAN_ESC: begin
                if (is_simple) begin
                    scan_st = SCAN_TEXT;
                    emit_res(simple, KIND_DATA);
                    if (lst) emit_res(8'h00, KIND_END);
                end else if (c == CH_X) begin
                    clear_run();
                    if (lst) begin
                        raise_err(1'b1);
                    end else begin
                        scan_st = SCAN_HEX;
                    end
                end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    clear_run();
                    run_val = {28'd0, c[2:0]};
                    scan_st = SCAN_OCT;
                    if (lst) begin
                        close_run();
                        emit_res(8'h00, KIND_END);
                    end
                end else begin
                    raise_err(lst);
                end
            end
            SCAN_HEX: begin
                if (is_hex) begin
                    accum(16, digit[3:0]);
                    run_hex = 1'b1;
                    if (lst) begin
                        close_run();
                        emit_res(8'h00, KIND_END);
                    end
                end else if (!run_hex) begin
                    raise_err(lst);
                end else begin
                    close_run();
                    plain_byte(c, lst);
                end
            end
            SCAN_OCT: begin
                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    accum(8, {1'b0, c[2:0]});
                    if (lst) begin
                        close_run();
                        emit_res(8'h00, KIND_END);
                    end
                end else begin
                    close_run();
                    plain_byte(c, lst);
                end
            end
            default: plain_byte(c, lst);
        endcase
    endtask

    // -------------------------------------------------------------------------
    // Stimulus
    // -------------------------------------------------------------------------

    task automatic push_req(input logic [7:0] d, input logic lst);
        req_t r;
        r.data = d;
        r.last = lst;
        byte_q.insert(byte_q.size(), r);
    endtask

    // Mostly well-formed strings with random content; some carry a bad escape,
    // a dangling backslash, or are plain noise with a random end flag.
    task automatic make_string();
        logic [7:0]  s[$];
        int unsigned ntok;
        int unsigned pick;
        int unsigned ndig;
        logic [7:0]  b;
        if ($urandom_range(0, 99) < 8) begin
            ntok = $urandom_range(1, 6);
            for (int i = 0; i < ntok; i++) begin
                push_req(8'($urandom), 1'($urandom));
            end
            return;
        end
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                b = 8'($urandom);
                if (b == CH_BSLASH) b = "A";
                s.insert(s.size(), b);
            end else if (pick < 50) begin
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), esc_set[$urandom_range(0, esc_set.len() - 1)]);
            end else if (pick < 65) begin
                // long runs now and then, to reach saturation
                s.insert(s.size(), CH_BSLASH);
                s.insert(s.size(), CH_X);
                ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 10)
                                                   : $urandom_range(1, 3);
                for (int i = 0; i < ndig; i++) begin
                    s.insert(s.size(), hex_set[$urandom_range(0, hex_set.len() - 1)]);
                end
            end else if (pick < 80) begin
                s.insert(s.size(), CH_BSLASH);
                ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13)
                                                   : $urandom_range(1, 3);
                for (int i = 0; i < ndig; i++) begin
                    s.insert(s.size(), CH_ZERO + 8'($urandom_range(0, 7)));
                end
            end else if (pick < 92) begin
                s.insert(s.size(), CH_BSLASH);
                case ($urandom_range(0, 4))
                    0: s.insert(s.size(), CH_U);
                    1: s.insert(s.size(), "U");
                    2: begin
                        s.insert(s.size(), CH_X);
                        s.insert(s.size(), "g");
                    end
                    3: s.insert(s.size(), CH_X);
                    default: s.insert(s.size(), 8'($urandom));
                endcase
            end else begin
                s.insert(s.size(), 8'($urandom));
            end
        end
        if ($urandom_range(0, 9) == 0) s.insert(s.size(), CH_BSLASH);
        for (int i = 0; i < s.size(); i++) begin
            push_req(s[i], i == s.size() - 1);
        end
    endtask

    // gap length between requests or ready pulses; zero throughout a calm stretch
    function automatic int unsigned next_gap(input logic calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // -------------------------------------------------------------------------
    // Input driver: falling edge, holds the request until it is taken
    // -------------------------------------------------------------------------

    int unsigned send_gap  = 0;
    logic        send_calm = 1'b0;
    req_t        next_req;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                next_req = byte_q.pop_front();
                s_in_byte <= next_req.data;
                s_last    <= next_req.last;
                s_valid   <= 1'b1;
                if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
                send_gap = next_gap(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, independent of m_valid
    int unsigned recv_gap  = 0;
    logic        recv_calm = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 79) == 0) recv_calm = !recv_calm;
            recv_gap = next_gap(recv_calm);
        end
    end

    // -------------------------------------------------------------------------
    // Monitor: rising edge, predicts taken requests and checks results
    // -------------------------------------------------------------------------

    task automatic log_fault(input string what);
        fault_cnt = fault_cnt + 1;
        if (fault_cnt <= 10) $display("[%0t] %s", $realtime, what);
    endtask

    result_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            req_taken = s_valid && s_ready;
            if (req_taken) begin
                decode_byte(s_in_byte, s_last);
                taken_cnt = taken_cnt + 1;
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    log_fault($sformatf("unexpected result: byte %02h kind %0d",
                                        m_out_byte, m_kind));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.data || m_kind !== want.kind) begin
                        log_fault($sformatf(
                            "mismatch: expected byte %02h kind %0d, got byte %02h kind %0d",
                            want.data, want.kind, m_out_byte, m_kind));
                    end
                end
            end
        end else begin
            req_taken = 1'b0;
        end
    end

    // -------------------------------------------------------------------------
    // Sequence
    // -------------------------------------------------------------------------

    initial begin
        // single plain byte closing a string
        push_req("A", 1'b1);
        // extreme byte values pass through untouched
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b1);
        // simple escape on the last byte
        push_req(CH_BSLASH, 1'b0);
        push_req("n", 1'b1);
        // hex run closed by a plain byte
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_X, 1'b0);
        push_req("4", 1'b0);
        push_req("1", 1'b0);
        push_req("z", 1'b1);
        // octal run closed by the end flag
        push_req(CH_BSLASH, 1'b0);
        push_req("1", 1'b0);
        push_req(CH_ZERO, 1'b0);
        push_req("1", 1'b1);
        // backslash as the final byte
        push_req(CH_BSLASH, 1'b1);
        // \x with no digit, tail dropped up to the end flag
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_X, 1'b0);
        push_req("g", 1'b0);
        push_req("q", 1'b1);
        // unicode escape rejected on the last byte
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_U, 1'b1);
        // octal run closed by a byte that opens another escape
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_SEVEN, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req("t", 1'b1);

        while (byte_q.size() < 420) make_string();
        total_reqs = byte_q.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (taken_cnt < total_reqs) @(posedge aclk);
        while (decoded_q.size() != 0) @(posedge aclk);
        // let any stray result surface
        repeat (20) @(posedge aclk);

        if (fault_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
